// ===== rtl/calle_pkg.sv =====
// Shared types and codes for the cursor array list engine.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package calle_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 4;
  localparam int STAT_W = 2;
  localparam int POS_W  = 7;

  // Operation kinds
  localparam logic [KIND_W-1:0] K_CLEAR    = 4'd0;
  localparam logic [KIND_W-1:0] K_APPEND   = 4'd1;
  localparam logic [KIND_W-1:0] K_INSERT   = 4'd2;
  localparam logic [KIND_W-1:0] K_REMOVE   = 4'd3;
  localparam logic [KIND_W-1:0] K_START    = 4'd4;
  localparam logic [KIND_W-1:0] K_END      = 4'd5;
  localparam logic [KIND_W-1:0] K_FORWARD  = 4'd6;
  localparam logic [KIND_W-1:0] K_BACKWARD = 4'd7;
  localparam logic [KIND_W-1:0] K_READ     = 4'd8;
  localparam logic [KIND_W-1:0] K_REVERSE  = 4'd9;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOVALUE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BOUNDARY = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         length;
    logic [POS_W-1:0]         cursor;
  } result_t;

endpackage

// ===== rtl/calle_mem.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on calle_pkg for the word width.
module calle_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [calle_pkg::DATA_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [calle_pkg::DATA_W-1:0] rdata
);

  logic [calle_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/calle_ctl.sv =====
// Sequencer for the list engine: length, cursor, index step unit and
// the memory access schedule. Depends on calle_pkg and calle_mem.
module calle_ctl #(
  parameter int CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  calle_pkg::item_t             item,
  input  logic                         take,
  output logic                         idle,
  output logic                         done,
  output calle_pkg::result_t           res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_SH_RD, S_SH_WR, S_FILL, S_DN_RD, S_DN_WR, S_RD_WAIT,
    S_RV_RLO, S_RV_RHI, S_RV_WLO, S_RV_WHI, S_DONE
  } state_t;

  state_t                            state;
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     position;
  logic [CW-1:0]                     idx;
  logic [CW-1:0]                     lo;
  logic [CW-1:0]                     hi;
  logic [calle_pkg::DATA_W-1:0]      word;
  logic [calle_pkg::DATA_W-1:0]      hold;
  logic [calle_pkg::DATA_W-1:0]      rd;
  logic [calle_pkg::STAT_W-1:0]      status;

  logic [CW-1:0]                     gap;
  logic [CW-1:0]                     idx_dec;
  logic [CW-1:0]                     idx_inc;
  logic                              full;
  logic [CW+calle_pkg::POS_W-1:0]    count_ext;
  logic [CW+calle_pkg::POS_W-1:0]    pos_ext;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [calle_pkg::DATA_W-1:0]      mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  logic [calle_pkg::DATA_W-1:0]      mem_rdata;

  calle_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign gap     = count - position;
  assign idx_dec = idx - CW'(1);
  assign idx_inc = idx + CW'(1);
  assign full    = (count == CW'(CAPACITY));

  // Memory access schedule
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        if (start && item.kind == calle_pkg::K_APPEND && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count[AW-1:0];
          mem_wdata = item.value;
        end
        if (start && item.kind == calle_pkg::K_READ && gap != '0) begin
          mem_re    = 1'b1;
          mem_raddr = position[AW-1:0];
        end
      end
      S_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_dec[AW-1:0];
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = position[AW-1:0];
        mem_wdata = word;
      end
      S_DN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_inc[AW-1:0];
      end
      S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_RV_RLO: begin
        mem_re    = 1'b1;
        mem_raddr = lo[AW-1:0];
      end
      S_RV_RHI: begin
        mem_re    = 1'b1;
        mem_raddr = hi[AW-1:0];
      end
      S_RV_WLO: begin
        mem_we    = 1'b1;
        mem_waddr = lo[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_RV_WHI: begin
        mem_we    = 1'b1;
        mem_waddr = hi[AW-1:0];
        mem_wdata = hold;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      position <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            rd   <= '0;
            word <= item.value;
            lo   <= position;
            hi   <= count - CW'(1);
            // Remove walks up from the cursor; insert walks down from the tail
            if (item.kind == calle_pkg::K_REMOVE) idx <= position;
            else idx <= count;
            case (item.kind)
              calle_pkg::K_CLEAR: begin
                count    <= '0;
                position <= '0;
                status   <= calle_pkg::ST_OK;
                state    <= S_DONE;
              end
              calle_pkg::K_APPEND: begin
                state <= S_DONE;
                if (full) begin
                  status <= calle_pkg::ST_FULL;
                end else begin
                  status <= calle_pkg::ST_OK;
                  count  <= count + CW'(1);
                end
              end
              calle_pkg::K_INSERT: begin
                if (full) begin
                  status <= calle_pkg::ST_FULL;
                  state  <= S_DONE;
                end else begin
                  status <= calle_pkg::ST_OK;
                  if (gap != '0) state <= S_SH_RD;
                  else state <= S_FILL;
                end
              end
              calle_pkg::K_REMOVE: begin
                if (gap == '0) begin
                  status <= calle_pkg::ST_NOVALUE;
                  state  <= S_DONE;
                end else begin
                  status <= calle_pkg::ST_OK;
                  if (gap > CW'(1)) begin
                    state <= S_DN_RD;
                  end else begin
                    count <= count - CW'(1);
                    state <= S_DONE;
                  end
                end
              end
              calle_pkg::K_START: begin
                position <= '0;
                status   <= calle_pkg::ST_OK;
                state    <= S_DONE;
              end
              calle_pkg::K_END: begin
                position <= count;
                status   <= calle_pkg::ST_OK;
                state    <= S_DONE;
              end
              calle_pkg::K_FORWARD: begin
                state <= S_DONE;
                if (gap == '0) begin
                  status <= calle_pkg::ST_BOUNDARY;
                end else begin
                  status   <= calle_pkg::ST_OK;
                  position <= position + CW'(1);
                end
              end
              calle_pkg::K_BACKWARD: begin
                state <= S_DONE;
                if (position == '0) begin
                  status <= calle_pkg::ST_BOUNDARY;
                end else begin
                  status   <= calle_pkg::ST_OK;
                  position <= position - CW'(1);
                end
              end
              calle_pkg::K_READ: begin
                if (gap == '0) begin
                  status <= calle_pkg::ST_NOVALUE;
                  state  <= S_DONE;
                end else begin
                  status <= calle_pkg::ST_OK;
                  state  <= S_RD_WAIT;
                end
              end
              calle_pkg::K_REVERSE: begin
                status <= calle_pkg::ST_OK;
                if (gap > CW'(1)) state <= S_RV_RLO;
                else state <= S_DONE;
              end
              default: begin
                status <= calle_pkg::ST_OK;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          idx <= idx_dec;
          if (idx_dec > position) state <= S_SH_RD;
          else state <= S_FILL;
        end
        S_FILL: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DN_RD: state <= S_DN_WR;
        S_DN_WR: begin
          idx <= idx_inc;
          if (count - idx > CW'(2)) begin
            state <= S_DN_RD;
          end else begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_RD_WAIT: begin
          rd    <= mem_rdata;
          state <= S_DONE;
        end
        S_RV_RLO: state <= S_RV_RHI;
        S_RV_RHI: begin
          hold  <= mem_rdata;
          state <= S_RV_WLO;
        end
        S_RV_WLO: state <= S_RV_WHI;
        S_RV_WHI: begin
          lo <= lo + CW'(1);
          hi <= hi - CW'(1);
          if (hi - lo > CW'(2)) state <= S_RV_RLO;
          else state <= S_DONE;
        end
        S_DONE: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign count_ext = (CW + calle_pkg::POS_W)'(count);
  assign pos_ext   = (CW + calle_pkg::POS_W)'(position);

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  assign res.status     = status;
  assign res.read_value = rd;
  assign res.length     = count_ext[calle_pkg::POS_W-1:0];
  assign res.cursor     = pos_ext[calle_pkg::POS_W-1:0];

`ifndef SYNTH
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    position <= count) else $error("cursor beyond length");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("length beyond capacity");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE) else $error("item started while busy");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("read and write to the same entry");
`endif

endmodule

// ===== rtl/cursor_array_list_engine_unit.sv =====
// Clear/append/start/end/fwd/back/other kinds give their result directly; read waits for
// the registered read data; insert and remove shift the entries past the cursor one by one,
// and remove at the tail only shortens the list; reverse swaps the span pair by pair.
// Throughput: one word at a time; a new word is stalled until the shift/swap sequencer
// is through with the current one.
// Reset (rst, synchronous, active high) empties the list and sets the cursor to zero;
// entry contents are not cleared and are never read before being written.
module cursor_array_list_engine_unit #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  // Operation words
  input  logic               item_valid,
  output logic               item_stall,
  input  calle_pkg::item_t   item,
  // Result words
  output logic               result_valid,
  input  logic               result_stall,
  output calle_pkg::result_t result
);

  logic               ctl_idle;
  logic               ctl_done;
  logic               ctl_take;
  logic               accept;
  calle_pkg::result_t ctl_res;

  // Stall new words while the sequencer works on one; a finished result that
  // waits in the output register does not block the next word.
  assign item_stall = !ctl_idle;
  assign accept     = item_valid && !item_stall;

  // Move the finished result into the output register once it is free
  assign ctl_take = ctl_done && (!result_valid || !result_stall);

  calle_ctl #(.CAPACITY(CAPACITY)) u_ctl (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .item  (item),
    .take  (ctl_take),
    .idle  (ctl_idle),
    .done  (ctl_done),
    .res   (ctl_res)
  );

  // Output register: hold while stalled, load on take, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_take) begin
      result <= ctl_res;
    end
  end

endmodule

// ===== test/list_result_checker.sv =====
`timescale 1ns / 100ps
// Checker for the cursor array list engine: watches both word channels, predicts each result.
// Depends on calle_pkg for the item and result word types and the kind and status codes.
module list_result_checker #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  calle_pkg::item_t   item,
  input  logic               result_valid,
  input  logic               result_stall,
  input  calle_pkg::result_t result,
  output int                 mismatch_count,
  output int                 results_due
);

  // Shadow copy of the list contents, its length and its cursor.
  logic [calle_pkg::DATA_W-1:0] list_word [0:CAPACITY-1];
  int                           list_len;
  int                           list_cur;

  calle_pkg::result_t due_results[$];
  calle_pkg::result_t fresh;
  calle_pkg::result_t oldest;
  int                 fail_tally;

  // Advance the shadow list by one operation word and form the result it gives.
  task automatic apply_list_op(input calle_pkg::item_t op, output calle_pkg::result_t res);
    int                           i;
    int                           lo;
    int                           hi;
    logic [calle_pkg::DATA_W-1:0] tmp;
    logic [calle_pkg::STAT_W-1:0] st;
    logic [calle_pkg::DATA_W-1:0] rd;
    st = calle_pkg::ST_OK;
    rd = '0;
    case (op.kind)
      calle_pkg::K_CLEAR: begin
        list_len = 0;
        list_cur = 0;
      end
      calle_pkg::K_APPEND: begin
        if (list_len >= CAPACITY) begin
          st = calle_pkg::ST_FULL;
        end else begin
          list_word[list_len] = op.value;
          list_len++;
        end
      end
      calle_pkg::K_INSERT: begin
        if (list_len >= CAPACITY) begin
          st = calle_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > list_cur; i--) list_word[i] = list_word[i-1];
          list_word[list_cur] = op.value;
          list_len++;
        end
      end
      calle_pkg::K_REMOVE: begin
        if (list_cur >= list_len) begin
          st = calle_pkg::ST_NOVALUE;
        end else begin
          for (i = list_cur; i + 1 < list_len; i++) list_word[i] = list_word[i+1];
          list_len--;
        end
      end
      calle_pkg::K_START: list_cur = 0;
      calle_pkg::K_END:   list_cur = list_len;
      calle_pkg::K_FORWARD: begin
        if (list_cur >= list_len) st = calle_pkg::ST_BOUNDARY;
        else list_cur++;
      end
      calle_pkg::K_BACKWARD: begin
        if (list_cur == 0) st = calle_pkg::ST_BOUNDARY;
        else list_cur--;
      end
      calle_pkg::K_READ: begin
        if (list_cur >= list_len) st = calle_pkg::ST_NOVALUE;
        else rd = list_word[list_cur];
      end
      calle_pkg::K_REVERSE: begin
        lo = list_cur;
        hi = list_len - 1;
        while (lo < hi) begin
          tmp           = list_word[lo];
          list_word[lo] = list_word[hi];
          list_word[hi] = tmp;
          lo++;
          hi--;
        end
      end
      default: ;
    endcase
    res.status     = st;
    res.read_value = rd;
    res.length     = calle_pkg::POS_W'(list_len);
    res.cursor     = calle_pkg::POS_W'(list_cur);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_results.delete();
      list_len = 0;
      list_cur = 0;
    end else begin
      // Retire the result first, so a word accepted at this edge cannot match it.
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d value %0d length %0d cursor %0d",
                   $time, result.status, result.read_value, result.length, result.cursor);
          fail_tally++;
        end else begin
          oldest = due_results.pop_front();
          check_field("status", oldest.status, result.status);
          check_field("read_value", oldest.read_value, result.read_value);
          check_field("length", oldest.length, result.length);
          check_field("cursor", oldest.cursor, result.cursor);
        end
      end
      if (item_valid && !item_stall) begin
        apply_list_op(item, fresh);
        due_results.push_back(fresh);
      end
    end
    results_due    <= due_results.size();
    mismatch_count <= fail_tally;
  end

endmodule

// ===== test/tb_cursor_array_list_engine_unit.sv =====
`timescale 1ns / 100ps
// Regression bench for cursor_array_list_engine_unit: directed then random operation words.
// Depends on calle_pkg, the engine itself and list_result_checker, which does the comparing.
module tb_cursor_array_list_engine_unit;

  localparam int CAPACITY   = 64;
  localparam int RANDOM_OPS = 2000;
  localparam int PHASE_OPS  = 60;
  localparam int DRAIN_SPAN = 500;
  // Slowest legal word is a full-length shift or swap, plus the widest gaps on both
  // sides; allow ten times that.
  localparam int IDLE_LIMIT = 1500;
  localparam int TAIL_WAIT  = 2 * CAPACITY + 16;

  // Kind codes past reverse do nothing; the bench still sends them.
  localparam logic [calle_pkg::KIND_W-1:0] KIND_SPARE_LO =
    calle_pkg::KIND_W'(calle_pkg::K_REVERSE + 1);
  localparam logic [calle_pkg::KIND_W-1:0] KIND_SPARE_HI = '1;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  calle_pkg::item_t   item         = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  calle_pkg::result_t result;

  int mismatch_count;
  int results_due;

  // Steering hint taken from accepted results; it lags a little.
  int seen_len = 0;

  int send_calm = 0;
  int recv_calm = 0;
  int idle_cycles = 0;

  cursor_array_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  list_result_checker #(
    .CAPACITY(CAPACITY)
  ) list_check (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .mismatch_count(mismatch_count),
    .results_due   (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Draw a random wait; now and then fall into a calm stretch with no waits.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // Bias the word values toward the extremes of the signed range.
  function automatic logic signed [calle_pkg::DATA_W-1:0] draw_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'shffffffff;
      3:       return 32'sh00000000;
      default: return $urandom();
    endcase
  endfunction

  // Pick an operation that pulls the list length toward the phase target.
  function automatic logic [calle_pkg::KIND_W-1:0] draw_kind(input int target);
    logic [calle_pkg::KIND_W-1:0] moves [6];
    int grow_w;
    int shrink_w;
    int r;
    moves    = '{calle_pkg::K_START, calle_pkg::K_END, calle_pkg::K_FORWARD,
                 calle_pkg::K_BACKWARD, calle_pkg::K_READ, calle_pkg::K_REVERSE};
    grow_w   = (seen_len < target) ? ((target == CAPACITY) ? 85 : 50)
                                   : ((target == CAPACITY) ? 30 : 4);
    shrink_w = (seen_len > target) ? 35 : 8;
    r        = $urandom_range(0, 99);
    if (r < grow_w) begin
      return ($urandom_range(0, 1) != 0) ? calle_pkg::K_APPEND : calle_pkg::K_INSERT;
    end
    if (r < grow_w + shrink_w) return calle_pkg::K_REMOVE;
    r = $urandom_range(0, 99);
    if (r < 2) return calle_pkg::K_CLEAR;
    if (r < 6) return calle_pkg::KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    return moves[$urandom_range(0, 5)];
  endfunction

  // Offer one operation word and hold it until the engine takes it. Valid stays high
  // afterwards; the next call decides whether to drop it, so it is set once per step.
  task automatic send_word(input logic [calle_pkg::KIND_W-1:0]        kind,
                           input logic signed [calle_pkg::DATA_W-1:0] value);
    int   gap;
    logic stalled;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{kind: kind, value: value};
    // Sample stall mid-cycle, where it is settled for the coming edge.
    do begin
      @(negedge clk);
      stalled = item_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic drain_results();
    logic done;
    item_valid <= 1'b0;
    do begin
      @(negedge clk);
      done = (results_due == 0);
      @(posedge clk);
    end while (!done);
  endtask

  // Receiver: stall for a drawn number of cycles, then take one result word.
  initial begin : result_sink
    int                 gap;
    logic               seen;
    calle_pkg::result_t snap;
    forever begin
      gap = draw_wait(recv_calm);
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        result_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        seen = result_valid;
        snap = result;
        @(posedge clk);
      end while (!seen);
      seen_len = snap.length;
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d results due", $time, results_due);
        $display("cursor_array_list_engine_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty list: every bounded operation hits its limit, reverse has no span.
    send_word(calle_pkg::K_READ, '0);
    send_word(calle_pkg::K_REMOVE, '0);
    send_word(calle_pkg::K_FORWARD, '0);
    send_word(calle_pkg::K_BACKWARD, '0);
    send_word(calle_pkg::K_REVERSE, '0);
    // Build a short list from the value extremes.
    send_word(calle_pkg::K_APPEND, 32'sh7fffffff);
    send_word(calle_pkg::K_APPEND, 32'sh80000000);
    send_word(calle_pkg::K_APPEND, 32'shffffffff);
    send_word(calle_pkg::K_APPEND, 32'sh00000000);
    // Insert at the head, then walk in and insert and remove mid-list.
    send_word(calle_pkg::K_START, '0);
    send_word(calle_pkg::K_INSERT, 32'sh0f0f0f0f);
    send_word(calle_pkg::K_FORWARD, '0);
    send_word(calle_pkg::K_FORWARD, '0);
    send_word(calle_pkg::K_READ, '0);
    send_word(calle_pkg::K_INSERT, -32'sd5);
    send_word(calle_pkg::K_REMOVE, '0);
    // Cursor at the tail: read has no value, forward is at the boundary.
    send_word(calle_pkg::K_END, '0);
    send_word(calle_pkg::K_READ, '0);
    send_word(calle_pkg::K_FORWARD, '0);
    // One-entry span, then the whole list.
    send_word(calle_pkg::K_BACKWARD, '0);
    send_word(calle_pkg::K_REVERSE, '0);
    send_word(calle_pkg::K_START, '0);
    send_word(calle_pkg::K_REVERSE, '0);
    send_word(calle_pkg::K_READ, '0);
    // Spare kind codes leave everything alone; then empty the list.
    send_word(KIND_SPARE_HI, 32'sh5a5a5a5a);
    send_word(KIND_SPARE_LO, '0);
    send_word(calle_pkg::K_CLEAR, '0);

    drain_results();

    // Random phases: each picks a length to aim for, mostly short, sometimes half or full.
    target = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % PHASE_OPS == 0) begin
        case ($urandom_range(0, 7))
          0:       target = CAPACITY;
          1:       target = CAPACITY / 2;
          default: target = $urandom_range(0, 12);
        endcase
      end
      if (n % DRAIN_SPAN == DRAIN_SPAN - 1) drain_results();
      send_word(draw_kind(target), draw_value());
    end

    // Everything is sent; wait for the last results and then let the engine settle.
    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("cursor_array_list_engine_unit regression: pass");
    end else begin
      $display("cursor_array_list_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== cursor_array_list_engine_unit.f =====
rtl/calle_pkg.sv
rtl/calle_mem.sv
rtl/calle_ctl.sv
rtl/cursor_array_list_engine_unit.sv
test/list_result_checker.sv
test/tb_cursor_array_list_engine_unit.sv
